FILE: design/blt_pkg.sv
// Package for the buffer lease tracker: field widths, event and result codes,
// sequencer state type. No dependencies; used by the interfaces and the top level.
package blt_pkg;

    localparam int MODE_W  = 3;
    localparam int SLOT_W  = 32;
    localparam int ACT_W   = 3;
    localparam int COUNT_W = 4;
    localparam int TOTAL_W = 64;

    localparam int MAX_BUFFERS_DEF = 8;

    localparam logic [SLOT_W-1:0] SLOT_NONE = '1;

    localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FRAME   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DRAIN   = 3'd4;

    localparam logic [ACT_W-1:0] ACT_DONE      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FORCED    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_IMMEDIATE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RELEASED  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NOT_FOUND = 3'd4;
    localparam logic [ACT_W-1:0] ACT_ASSIGNED  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_FULL      = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FORCE_CHK,
        ST_FORCE_RD,
        ST_FORCE_EMIT,
        ST_APPEND,
        ST_REPLY
    } blt_state_t;

endpackage

FILE: design/blt_if.sv
// Valid/ready channel interfaces for the buffer lease tracker event and result items.
// Depends on blt_pkg for field widths.
interface blt_req_if;
    logic                         valid;
    logic                         ready;
    logic [blt_pkg::MODE_W-1:0]   mode;
    logic [blt_pkg::SLOT_W-1:0]   slot_id;
    logic                         tracked;

    modport source (output valid, mode, slot_id, tracked, input ready);
    modport sink (input valid, mode, slot_id, tracked, output ready);
endinterface

interface blt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [blt_pkg::ACT_W-1:0]     action;
    logic [blt_pkg::SLOT_W-1:0]    result_slot;
    logic                          last;
    logic [blt_pkg::COUNT_W-1:0]   held_now;
    logic [blt_pkg::COUNT_W-1:0]   pool_size;
    logic [blt_pkg::TOTAL_W-1:0]   forced_total;

    modport source (output valid, action, result_slot, last, held_now, pool_size,
                    forced_total, input ready);
    modport sink (input valid, action, result_slot, last, held_now, pool_size,
                  forced_total, output ready);
endinterface

FILE: design/blt_ram.sv
// Held-slot list storage: one write port, one read port with registered data.
// No dependencies.
module blt_ram #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: design/buffer_lease_tracker.sv
// Buffer lease tracker: event channel req, result channel rsp.
// Holds the held-slot list as a ring in a small RAM, walked by one sequencer.
//
// Each event item on req yields one or more result items on rsp, the final one
// flagged by last. req.ready is high only while the sequencer is idle; it rises
// again in the same cycle that the final result of an item enters the output
// register, so the next event can be taken while that result still waits on rsp.
// Add, a frame handed back at once, a drain of an empty list and an unknown mode
// go straight to the reply. Release and remove compare the held entries in turn
// and, after a hit, move each younger entry up one place. A held frame may hand
// back the oldest entries as forced results before its final result; a drain
// hands back every held entry, the last one flagged as final.
// Every list step is split into a RAM read state and a state that uses the read
// data, because the single RAM read port is registered. Each held entry is either
// compared or moved.
// Reset clears the counters, the slot id counter, the ring head and the output
// valid; list contents are left as they are and never read before written.
// A stall on rsp holds the current result; the sequencer runs on until it has
// its next result to load and waits there.
module buffer_lease_tracker #(
    parameter int MAX_BUFFERS = blt_pkg::MAX_BUFFERS_DEF
) (
    input logic clk,
    input logic rst_n,
    blt_req_if.sink   req,
    blt_rsp_if.source rsp
);

    import blt_pkg::*;

    localparam int IDX_W = $clog2(MAX_BUFFERS);
    localparam int CNT_W = $clog2(MAX_BUFFERS + 1);
    localparam int SUM_W = $clog2(2 * MAX_BUFFERS);

    function automatic logic [IDX_W-1:0] ring_at(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(MAX_BUFFERS))
        begin
            sum = sum - SUM_W'(MAX_BUFFERS);
        end
        return sum[IDX_W-1:0];
    endfunction

    blt_state_t state_reg, state_next;

    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [ACT_W-1:0]   reply_action_reg, reply_action_next;
    logic [SLOT_W-1:0]  reply_slot_reg, reply_slot_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   held_count_reg, held_count_next;
    logic [CNT_W-1:0]   buffer_count_reg, buffer_count_next;
    logic [SLOT_W-1:0]  next_slot_reg, next_slot_next;
    logic [TOTAL_W-1:0] forced_count_reg, forced_count_next;

    logic               out_valid_reg, out_valid_next;
    logic [ACT_W-1:0]   out_action_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic               out_last_reg;
    logic [COUNT_W-1:0] out_held_reg;
    logic [COUNT_W-1:0] out_pool_reg;
    logic [TOTAL_W-1:0] out_forced_reg;

    logic               out_free;
    logic               out_load;
    logic [ACT_W-1:0]   emit_action;
    logic [SLOT_W-1:0]  emit_slot;
    logic               emit_last;
    logic [CNT_W-1:0]   idx_inc;

    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [SLOT_W-1:0]  ram_wr_data;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [SLOT_W-1:0]  ram_rd_data;

    blt_ram #(
        .DEPTH  (MAX_BUFFERS),
        .ADDR_W (IDX_W),
        .DATA_W (SLOT_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_free = !out_valid_reg || rsp.ready;
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        slot_next         = slot_reg;
        reply_action_next = reply_action_reg;
        reply_slot_next   = reply_slot_reg;
        idx_next          = idx_reg;
        head_next         = head_reg;
        held_count_next   = held_count_reg;
        buffer_count_next = buffer_count_reg;
        next_slot_next    = next_slot_reg;
        forced_count_next = forced_count_reg;
        out_load          = 1'b0;
        emit_action       = ACT_DONE;
        emit_slot         = '0;
        emit_last         = 1'b0;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = '0;
        ram_wr_data       = slot_reg;
        ram_rd_addr       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next = req.mode;
                    slot_next = req.slot_id;
                    idx_next  = '0;
                    unique case (req.mode)
                        MODE_ADD:
                        begin
                            if (buffer_count_reg >= CNT_W'(MAX_BUFFERS))
                            begin
                                reply_action_next = ACT_FULL;
                                reply_slot_next   = '0;
                            end
                            else
                            begin
                                next_slot_next    = next_slot_reg + SLOT_W'(1);
                                buffer_count_next = buffer_count_reg + CNT_W'(1);
                                reply_action_next = ACT_ASSIGNED;
                                reply_slot_next   = next_slot_reg;
                            end
                            state_next = ST_REPLY;
                        end
                        MODE_REMOVE:
                        begin
                            if (buffer_count_reg != '0)
                            begin
                                buffer_count_next = buffer_count_reg - CNT_W'(1);
                            end
                            state_next = ST_SRCH_RD;
                        end
                        MODE_FRAME:
                        begin
                            if (!req.tracked || req.slot_id == SLOT_NONE)
                            begin
                                reply_action_next = ACT_IMMEDIATE;
                                reply_slot_next   = SLOT_NONE;
                                state_next        = ST_REPLY;
                            end
                            else if (buffer_count_reg <= CNT_W'(1))
                            begin
                                reply_action_next = ACT_IMMEDIATE;
                                reply_slot_next   = req.slot_id;
                                state_next        = ST_REPLY;
                            end
                            else
                            begin
                                state_next = ST_FORCE_CHK;
                            end
                        end
                        MODE_RELEASE:
                        begin
                            state_next = ST_SRCH_RD;
                        end
                        MODE_DRAIN:
                        begin
                            if (held_count_reg == '0)
                            begin
                                reply_action_next = ACT_DONE;
                                reply_slot_next   = '0;
                                state_next        = ST_REPLY;
                            end
                            else
                            begin
                                state_next = ST_FORCE_RD;
                            end
                        end
                        default:
                        begin
                            reply_action_next = ACT_DONE;
                            reply_slot_next   = '0;
                            state_next        = ST_REPLY;
                        end
                    endcase
                end
            end
            ST_SRCH_RD:
            begin
                if (idx_reg >= held_count_reg)
                begin
                    reply_action_next = (mode_reg == MODE_RELEASE) ? ACT_NOT_FOUND : ACT_DONE;
                    reply_slot_next   = slot_reg;
                    state_next        = ST_REPLY;
                end
                else
                begin
                    ram_rd_addr = ring_at(head_reg, idx_reg);
                    state_next  = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP:
            begin
                if (ram_rd_data == slot_reg)
                begin
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SHIFT_RD:
            begin
                // close the gap: move each younger entry one place toward the head
                if (idx_inc < held_count_reg)
                begin
                    ram_rd_addr = ring_at(head_reg, idx_inc);
                    state_next  = ST_SHIFT_WR;
                end
                else
                begin
                    held_count_next   = held_count_reg - CNT_W'(1);
                    reply_action_next = (mode_reg == MODE_RELEASE) ? ACT_RELEASED : ACT_DONE;
                    reply_slot_next   = slot_reg;
                    state_next        = ST_REPLY;
                end
            end
            ST_SHIFT_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = ring_at(head_reg, idx_reg);
                ram_wr_data = ram_rd_data;
                idx_next    = idx_inc;
                state_next  = ST_SHIFT_RD;
            end
            ST_FORCE_CHK:
            begin
                if (held_count_reg != '0 &&
                    ((CNT_W+1)'(held_count_reg) + (CNT_W+1)'(1)) >=
                    (CNT_W+1)'(buffer_count_reg))
                begin
                    state_next = ST_FORCE_RD;
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_FORCE_RD:
            begin
                ram_rd_addr = head_reg;
                state_next  = ST_FORCE_EMIT;
            end
            ST_FORCE_EMIT:
            begin
                ram_rd_addr = head_reg;
                if (out_free)
                begin
                    out_load          = 1'b1;
                    emit_action       = ACT_FORCED;
                    emit_slot         = ram_rd_data;
                    emit_last         = (mode_reg == MODE_DRAIN) &&
                                        (held_count_reg == CNT_W'(1));
                    head_next         = (head_reg == IDX_W'(MAX_BUFFERS - 1)) ?
                                        '0 : head_reg + IDX_W'(1);
                    held_count_next   = held_count_reg - CNT_W'(1);
                    forced_count_next = forced_count_reg + TOTAL_W'(1);
                    if (mode_reg == MODE_DRAIN)
                    begin
                        state_next = (held_count_reg == CNT_W'(1)) ? ST_IDLE : ST_FORCE_RD;
                    end
                    else
                    begin
                        state_next = ST_FORCE_CHK;
                    end
                end
            end
            ST_APPEND:
            begin
                if (out_free)
                begin
                    if (held_count_reg < CNT_W'(MAX_BUFFERS))
                    begin
                        ram_wr_en       = 1'b1;
                        ram_wr_addr     = ring_at(head_reg, held_count_reg);
                        held_count_next = held_count_reg + CNT_W'(1);
                    end
                    out_load    = 1'b1;
                    emit_action = ACT_DONE;
                    emit_slot   = slot_reg;
                    emit_last   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    emit_action = reply_action_reg;
                    emit_slot   = reply_slot_reg;
                    emit_last   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            head_reg         <= '0;
            held_count_reg   <= '0;
            buffer_count_reg <= '0;
            next_slot_reg    <= '0;
            forced_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            head_reg         <= head_next;
            held_count_reg   <= held_count_next;
            buffer_count_reg <= buffer_count_next;
            next_slot_reg    <= next_slot_next;
            forced_count_reg <= forced_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg         <= mode_next;
        slot_reg         <= slot_next;
        reply_action_reg <= reply_action_next;
        reply_slot_reg   <= reply_slot_next;
        if (out_load)
        begin
            out_action_reg <= emit_action;
            out_slot_reg   <= emit_slot;
            out_last_reg   <= emit_last;
            out_held_reg   <= COUNT_W'(held_count_next);
            out_pool_reg   <= COUNT_W'(buffer_count_next);
            out_forced_reg <= forced_count_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.action       = out_action_reg;
    assign rsp.result_slot  = out_slot_reg;
    assign rsp.last         = out_last_reg;
    assign rsp.held_now     = out_held_reg;
    assign rsp.pool_size    = out_pool_reg;
    assign rsp.forced_total = out_forced_reg;

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= CNT_W'(MAX_BUFFERS))
        else $error("held count above pool limit");

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        buffer_count_reg <= CNT_W'(MAX_BUFFERS))
        else $error("buffer count above pool limit");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < IDX_W'(MAX_BUFFERS - 1) || head_reg == IDX_W'(MAX_BUFFERS - 1))
        else $error("ring head out of range");

    a_force_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FORCE_EMIT && out_free) |=>
        (forced_count_reg == $past(forced_count_reg) + TOTAL_W'(1) &&
         held_count_reg == $past(held_count_reg) - CNT_W'(1)))
        else $error("forced handback did not advance counters");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && emit_last) |=> state_reg == ST_IDLE)
        else $error("sequencer busy after final result");

endmodule

FILE: bench/tb_buffer_lease_tracker.sv
`timescale 1ns / 1ps
// Testbench for buffer_lease_tracker: directed and random event items, each result
// checked against an in-bench model of the held-slot list and its counters.
// Depends on blt_pkg, blt_req_if, blt_rsp_if and buffer_lease_tracker.
module tb_buffer_lease_tracker;
    import blt_pkg::*;

    localparam int POOL_MAX    = MAX_BUFFERS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 64;
    localparam int MODE_TOP    = (1 << MODE_W) - 1;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [SLOT_W-1:0]  slot;
        logic               last;
        logic [COUNT_W-1:0] held;
        logic [COUNT_W-1:0] pool;
        logic [TOTAL_W-1:0] forced;
    } lease_result_t;

    logic clk;
    logic rst_n;

    blt_req_if req_ch ();
    blt_rsp_if rsp_ch ();

    buffer_lease_tracker #(
        .MAX_BUFFERS(POOL_MAX)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    logic [SLOT_W-1:0]  held_list[$];
    int unsigned        pool_count = 0;
    logic [SLOT_W-1:0]  next_id = '0;
    logic [TOTAL_W-1:0] forced_count = '0;
    lease_result_t      pending_result;
    bit                 pending_valid = 1'b0;
    lease_result_t      expected_results[$];
    lease_result_t      seen_result;
    lease_result_t      want_result;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int results_seen = 0;
    int error_count = 0;
    int idle_cycles = 0;
    int full_seen = 0;

    function automatic void queue_result(logic [ACT_W-1:0] act, logic [SLOT_W-1:0] slot);
        if (pending_valid)
        begin
            expected_results.push_back(pending_result);
        end
        pending_result.action = act;
        pending_result.slot   = slot;
        pending_result.last   = 1'b0;
        pending_result.held   = COUNT_W'(held_list.size());
        pending_result.pool   = COUNT_W'(pool_count);
        pending_result.forced = forced_count;
        pending_valid = 1'b1;
    endfunction

    function automatic bit drop_held(logic [SLOT_W-1:0] id);
        foreach (held_list[i])
        begin
            if (held_list[i] == id)
            begin
                held_list.delete(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void force_oldest();
        logic [SLOT_W-1:0] s;
        s = held_list.pop_front();
        forced_count = forced_count + 1'b1;
        queue_result(ACT_FORCED, s);
    endfunction

    function automatic void predict_lease(logic [MODE_W-1:0] m, logic [SLOT_W-1:0] s,
                                          logic t);
        logic [SLOT_W-1:0] id;
        pending_valid = 1'b0;
        case (m)
            MODE_ADD:
            begin
                if (pool_count >= POOL_MAX)
                begin
                    queue_result(ACT_FULL, '0);
                end
                else
                begin
                    id = next_id;
                    next_id = next_id + 1'b1;
                    pool_count++;
                    queue_result(ACT_ASSIGNED, id);
                end
            end
            MODE_REMOVE:
            begin
                void'(drop_held(s));
                if (pool_count > 0)
                begin
                    pool_count--;
                end
                queue_result(ACT_DONE, s);
            end
            MODE_FRAME:
            begin
                if (!t || s == SLOT_NONE)
                begin
                    queue_result(ACT_IMMEDIATE, SLOT_NONE);
                end
                else if (pool_count <= 1)
                begin
                    queue_result(ACT_IMMEDIATE, s);
                end
                else
                begin
                    while (held_list.size() >= pool_count - 1 && held_list.size() > 0)
                    begin
                        force_oldest();
                    end
                    if (held_list.size() < POOL_MAX)
                    begin
                        held_list.push_back(s);
                    end
                    queue_result(ACT_DONE, s);
                end
            end
            MODE_RELEASE:
            begin
                if (drop_held(s))
                begin
                    queue_result(ACT_RELEASED, s);
                end
                else
                begin
                    queue_result(ACT_NOT_FOUND, s);
                end
            end
            MODE_DRAIN:
            begin
                if (held_list.size() == 0)
                begin
                    queue_result(ACT_DONE, '0);
                end
                while (held_list.size() > 0)
                begin
                    force_oldest();
                end
            end
            default:
            begin
                queue_result(ACT_DONE, '0);
            end
        endcase
        pending_result.last = 1'b1;
        expected_results.push_back(pending_result);
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60 && held_list.size() != 0)
        begin
            return held_list[$urandom_range(held_list.size() - 1)];
        end
        if (roll < 90)
        begin
            return next_id - 1 - $urandom_range(7);
        end
        return $urandom;
    endfunction

    task automatic send_event(logic [MODE_W-1:0] m, logic [SLOT_W-1:0] s, logic t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.mode    <= m;
        req_ch.slot_id <= s;
        req_ch.tracked <= t;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predict_lease(m, s, t);
        items_sent++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic test_idle_events();
        for (int m = int'(MODE_DRAIN) + 1; m <= MODE_TOP; m++)
        begin
            send_event(MODE_W'(m), SLOT_NONE, 1'b1);
        end
        send_event(MODE_DRAIN, '0, 1'b0);
        send_event(MODE_RELEASE, 32'hFFFF_FFFE, 1'b1);
        send_event(MODE_REMOVE, '0, 1'b0);
        send_event(MODE_FRAME, 32'h0000_0005, 1'b1);
        wait_drained();
    endtask

    task automatic test_small_pool();
        send_event(MODE_ADD, SLOT_NONE, 1'b1);
        send_event(MODE_FRAME, 32'h0000_0000, 1'b1);
        send_event(MODE_ADD, '0, 1'b0);
        send_event(MODE_ADD, '0, 1'b1);
        send_event(MODE_FRAME, 32'h0000_0000, 1'b1);
        send_event(MODE_FRAME, 32'h0000_0000, 1'b1);
        send_event(MODE_FRAME, 32'h0000_0001, 1'b1);
        send_event(MODE_RELEASE, 32'h0000_0000, 1'b0);
        send_event(MODE_RELEASE, 32'h0000_0000, 1'b1);
        send_event(MODE_FRAME, 32'h8000_0001, 1'b0);
        send_event(MODE_FRAME, SLOT_NONE, 1'b1);
        wait_drained();
    endtask

    task automatic test_pool_full();
        repeat (POOL_MAX - 3)
        begin
            send_event(MODE_ADD, '0, 1'b0);
        end
        send_event(MODE_ADD, 32'h5555_AAAA, 1'b1);
        send_event(MODE_FRAME, 32'h7FFF_FFFF, 1'b1);
        send_event(MODE_DRAIN, 32'hFFFF_FFFF, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_traffic(int count, int idle_pct, int stall, bit pressure);
        int roll;
        logic [MODE_W-1:0] m;
        logic [SLOT_W-1:0] s;
        logic t;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            t = ($urandom_range(99) < 92);
            s = pick_slot();
            if (roll < 15)
                m = MODE_ADD;
            else if (roll < 25)
                m = MODE_REMOVE;
            else if (roll < 65)
                m = MODE_FRAME;
            else if (roll < 83)
                m = MODE_RELEASE;
            else if (roll < 88)
                m = MODE_DRAIN;
            else if (roll < 93)
                m = MODE_W'($urandom_range(MODE_TOP, int'(MODE_DRAIN) + 1));
            else
            begin
                m = MODE_W'($urandom_range(MODE_TOP));
                s = (roll >= 98) ? SLOT_NONE : $urandom;
                t = 1'($urandom_range(1));
            end
            send_event(m, s, t);
            if (pressure && n % 15 == 14)
            begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            results_seen++;
            seen_result = {rsp_ch.action, rsp_ch.result_slot, rsp_ch.last, rsp_ch.held_now,
                           rsp_ch.pool_size, rsp_ch.forced_total};
            if (seen_result.action == ACT_FULL)
            begin
                full_seen++;
            end
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result act %0d slot %h last %0d", $time,
                         seen_result.action, seen_result.slot, seen_result.last);
            end
            else
            begin
                want_result = expected_results.pop_front();
                if (seen_result !== want_result)
                begin
                    error_count++;
                    $display("%0t: expected act %0d slot %h last %0d held %0d pool %0d forced %0d",
                             $time, want_result.action, want_result.slot, want_result.last,
                             want_result.held, want_result.pool, want_result.forced);
                    $display("%0t: actual   act %0d slot %h last %0d held %0d pool %0d forced %0d",
                             $time, seen_result.action, seen_result.slot, seen_result.last,
                             seen_result.held, seen_result.pool, seen_result.forced);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            || (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.mode    <= MODE_ADD;
        req_ch.slot_id <= '0;
        req_ch.tracked <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_events();
        test_small_pool();
        test_pool_full();
        test_random_traffic(46, 0, 0, 1'b0);
        test_random_traffic(46, 72, 0, 1'b0);
        test_random_traffic(46, 0, 72, 1'b1);
        test_random_traffic(47, 14, 14, 1'b0);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
        end
        $display("Sent %0d event items, checked %0d results under four idle/stall mixes;",
                 items_sent, results_seen);
        $display("saw %0d forced handbacks and %0d adds refused on a full pool.",
                 forced_count, full_seen);
        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
